### design/sadt_pkg.sv
// shared constants and codes for the sorted angle/distance table
`timescale 1ns / 1ps
`default_nettype none
package sadt_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ANG_W  = 19;
   localparam int DIST_W = 16;
   localparam int RIDX_W = 10;
   localparam int TOL_W  = 10;
   localparam int STAT_W = 3;
   localparam int EIDX_W = 10;
   localparam int TOT_W  = 11;
   localparam int ENT_W  = ANG_W + DIST_W;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 16;

   localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_KEPT     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_READ     = 3'd4;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   localparam logic [TOL_W-1:0] TOL_RESET = 10'd10;
endpackage
`default_nettype wire

### design/sorted_angle_distance_table.sv
// Sorted angle/distance table: one memory of entries kept in ascending angle order.
// A read item passes through the read-wait and done states to its result; when the index is
// at or above the count it goes straight to the done state. An insert item scans the stored
// entries one per cycle through the single read port of the entry memory (stopping at the
// first entry within match_tolerance, which is replaced or kept), then moves the entries
// above the insert point up by one, one entry per cycle, and writes the new pair; a full
// table gives the full status instead. One item is in work at a time; a finished result
// waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module sorted_angle_distance_table (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // angle_mdeg [18:0], distance [34:19], read_index [44:35]
   input  wire  [sadt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode [0]
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // entry_index [9:0], entry_angle [28:10], entry_distance [44:29], entry_total [55:45]
   output logic [sadt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status [2:0]
   output logic [sadt_pkg::STAT_W-1:0]          rsp_tuser,
   input  wire                                  csr_tvalid,
   output logic                                 csr_tready,
   // match_tolerance [9:0]
   input  wire  [sadt_pkg::CSR_DATA_W-1:0]      csr_tdata
);
   import sadt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_SEARCH,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [TOL_W-1:0]        tol_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [ANG_W-1:0]        ang_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic [IDX_W-1:0]        cmp_idx_ff;
   logic [IDX_W-1:0]        pos_ff;
   logic                    pos_found_ff;
   logic [IDX_W-1:0]        wr_tgt_ff;

   logic [STAT_W-1:0]       res_stat_ff;
   logic [EIDX_W-1:0]       res_idx_ff;
   logic [ANG_W-1:0]        res_ang_ff;
   logic [DIST_W-1:0]       res_dist_ff;

   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       rsp_stat_ff;
   logic [EIDX_W-1:0]       rsp_idx_ff;
   logic [ANG_W-1:0]        rsp_ang_ff;
   logic [DIST_W-1:0]       rsp_dist_ff;
   logic [TOT_W-1:0]        rsp_tot_ff;

   // entry memory: {angle, distance}
   logic [ENT_W-1:0]        mem [TABLE_DEPTH];
   logic [ENT_W-1:0]        rd_data_ff;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ENT_W-1:0]        wr_data;

   logic                    req_fire;
   logic                    in_mode;
   logic [ANG_W-1:0]        in_ang;
   logic [DIST_W-1:0]       in_dist;
   logic [RIDX_W-1:0]       in_ridx;
   logic                    ridx_ok;

   logic [ANG_W-1:0]        st_ang;
   logic [DIST_W-1:0]       st_dist;
   logic signed [ANG_W:0]   diff;
   logic [ANG_W:0]          abs_diff;
   logic                    is_match;
   logic                    is_above;
   logic                    is_last;
   logic                    is_full;
   logic [IDX_W-1:0]        final_pos;
   logic                    need_shift;
   logic                    shift_end;
   logic                    out_free;

   assign in_mode  = req_tuser;
   assign in_ang   = req_tdata[ANG_W-1:0];
   assign in_dist  = req_tdata[ANG_W+DIST_W-1:ANG_W];
   assign in_ridx  = req_tdata[ANG_W+DIST_W+RIDX_W-1:ANG_W+DIST_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_tready = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ridx_ok = ({{(32-RIDX_W){1'b0}}, in_ridx} < {{(32-CNT_W){1'b0}}, count_ff});

   assign st_ang   = rd_data_ff[ENT_W-1:DIST_W];
   assign st_dist  = rd_data_ff[DIST_W-1:0];
   assign diff     = $signed({st_ang[ANG_W-1], st_ang}) - $signed({ang_ff[ANG_W-1], ang_ff});
   assign abs_diff = diff[ANG_W] ? (ANG_W+1)'(0) - diff : diff;
   assign is_match = (abs_diff < {{(ANG_W+1-TOL_W){1'b0}}, tol_ff});
   assign is_above = ($signed(st_ang) > $signed(ang_ff));
   assign is_last  = ({1'b0, cmp_idx_ff} + CNT_W'(1) == count_ff);
   assign is_full  = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign final_pos  = (!pos_found_ff && is_above) ? cmp_idx_ff : pos_ff;
   assign need_shift = ({1'b0, final_pos} != count_ff);
   assign shift_end  = (wr_tgt_ff == pos_ff + IDX_W'(1));

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_en   = (in_mode == MODE_READ) ? ridx_ok : (count_ff != '0);
               rd_addr = (in_mode == MODE_READ) ? IDX_W'(in_ridx) : '0;
            end
         end
         ST_SEARCH: begin
            if (is_match) begin
               wr_en   = st_dist[DIST_W-1];
               wr_addr = cmp_idx_ff;
               wr_data = {st_ang, dist_ff};
            end else if (!is_last) begin
               rd_en   = 1'b1;
               rd_addr = cmp_idx_ff + IDX_W'(1);
            end else if (!is_full && need_shift) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(count_ff - CNT_W'(1));
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = wr_tgt_ff;
            wr_data = rd_data_ff;
            if (!shift_end) begin
               rd_en   = 1'b1;
               rd_addr = wr_tgt_ff - IDX_W'(2);
            end
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = {ang_ff, dist_ff};
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_tvalid && csr_tready) begin
         tol_ff <= csr_tdata[TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the done state the output register is reloaded below
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  ang_ff       <= in_ang;
                  dist_ff      <= in_dist;
                  cmp_idx_ff   <= '0;
                  pos_ff       <= IDX_W'(count_ff);
                  pos_found_ff <= 1'b0;
                  if (in_mode == MODE_READ) begin
                     res_stat_ff <= STAT_READ;
                     res_idx_ff  <= in_ridx;
                     res_ang_ff  <= '0;
                     res_dist_ff <= '0;
                     state_ff    <= ridx_ok ? ST_RD_WAIT : ST_DONE;
                  end else if (count_ff == '0) begin
                     state_ff <= ST_PLACE;
                  end else begin
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_RD_WAIT: begin
               res_ang_ff  <= st_ang;
               res_dist_ff <= st_dist;
               state_ff    <= ST_DONE;
            end
            ST_SEARCH: begin
               if (is_match) begin
                  res_idx_ff <= EIDX_W'(cmp_idx_ff);
                  res_ang_ff <= st_ang;
                  if (st_dist[DIST_W-1]) begin
                     res_stat_ff <= STAT_REPLACED;
                     res_dist_ff <= dist_ff;
                  end else begin
                     res_stat_ff <= STAT_KEPT;
                     res_dist_ff <= st_dist;
                  end
                  state_ff <= ST_DONE;
               end else if (!is_last) begin
                  cmp_idx_ff <= cmp_idx_ff + IDX_W'(1);
                  if (!pos_found_ff && is_above) begin
                     pos_ff       <= cmp_idx_ff;
                     pos_found_ff <= 1'b1;
                  end
               end else if (is_full) begin
                  res_stat_ff <= STAT_FULL;
                  res_idx_ff  <= '0;
                  res_ang_ff  <= ang_ff;
                  res_dist_ff <= dist_ff;
                  state_ff    <= ST_DONE;
               end else begin
                  pos_ff    <= final_pos;
                  wr_tgt_ff <= IDX_W'(count_ff);
                  state_ff  <= need_shift ? ST_SHIFT : ST_PLACE;
               end
            end
            ST_SHIFT: begin
               wr_tgt_ff <= wr_tgt_ff - IDX_W'(1);
               if (shift_end) begin
                  state_ff <= ST_PLACE;
               end
            end
            ST_PLACE: begin
               count_ff    <= count_ff + CNT_W'(1);
               res_stat_ff <= STAT_INSERTED;
               res_idx_ff  <= EIDX_W'(pos_ff);
               res_ang_ff  <= ang_ff;
               res_dist_ff <= dist_ff;
               state_ff    <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_stat_ff  <= res_stat_ff;
                  rsp_idx_ff   <= res_idx_ff;
                  rsp_ang_ff   <= res_ang_ff;
                  rsp_dist_ff  <= res_dist_ff;
                  rsp_tot_ff   <= TOT_W'(count_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {rsp_tot_ff, rsp_dist_ff, rsp_ang_ff, rsp_idx_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance entry count");

   a_shift_above_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> wr_tgt_ff > pos_ff)
      else $error("shift wrote at or below insert point");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> !is_full)
      else $error("insert into a full table");
`endif
endmodule
`default_nettype wire
